FILE: src/xed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xed_pkg: shared types and constants of the entity decoder
// Reference names, their replacement characters and the job word that the
// front end hands to the back end through the job queue.
// ----------------------------------------------------------------------------
package xed_pkg;

  localparam int unsigned NUM_NAMES = 4;
  localparam int unsigned NAME_MAX  = 5;  // longest name including ';'
  localparam int unsigned HELD_MAX  = 4;
  localparam int unsigned MAX_OUT   = 6;  // most words one input byte can cause

  localparam logic [7:0] AMP_CHAR = 8'h26;

  // Each name followed by its semicolon, zero padded
  localparam logic [7:0] NAME_TEXT [NUM_NAMES][NAME_MAX] = '{
    '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},  // quot;
    '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},  // amp;
    '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},  // lt;
    '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00}   // gt;
  };
  localparam logic [2:0] NAME_LEN  [NUM_NAMES] = '{3'd5, 3'd4, 3'd3, 3'd3};
  localparam logic [7:0] NAME_CHAR [NUM_NAMES] = '{8'h22, 8'h26, 8'h3C, 8'h3E};

  // Outcome of checking one byte against the pending reference
  typedef enum logic [1:0] {
    CLS_BREAK,
    CLS_PREFIX,
    CLS_FULL
  } cls_e;

  // One job: the output words caused by one input byte
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [2:0]              count;     // 1 to MAX_OUT
    logic                    text_end;  // caused by the final byte of the text
  } job_t;

endpackage
`default_nettype wire

FILE: src/xed_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xed_front: reference tracking and job building
// Keeps the pending reference state and turns each accepted byte that causes
// words into a job holding all the words that byte causes.
// ----------------------------------------------------------------------------
module xed_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          end_of_text_i,
  output logic               job_valid_o,
  output xed_pkg::job_t      job_o
);

  logic       in_ref_q, in_ref_d;
  logic [2:0] hc_q, hc_d;
  logic [7:0] held_q [xed_pkg::HELD_MAX];

  xed_pkg::cls_e cls;
  logic [1:0]    which;
  logic          ok;
  logic          found;

  logic       is_amp;
  logic       hold_ok, match, flush1, plain, emit_en, flush2;
  logic [7:0] emit_byte;
  logic [2:0] n;
  logic [xed_pkg::MAX_OUT-1:0][7:0] ob;

  // Match the byte against every name still consistent with the held letters
  always_comb begin
    cls   = xed_pkg::CLS_BREAK;
    which = '0;
    found = 1'b0;
    ok    = 1'b0;
    for (int i = 0; i < xed_pkg::NUM_NAMES; i++) begin
      ok = (hc_q < xed_pkg::NAME_LEN[i]);
      for (int k = 0; k < xed_pkg::HELD_MAX; k++) begin
        if (k < hc_q && held_q[k] != xed_pkg::NAME_TEXT[i][k]) begin
          ok = 1'b0;
        end
      end
      if (ok && !found && xed_pkg::NAME_TEXT[i][hc_q] == in_byte_i) begin
        found = 1'b1;
        which = 2'(i);
        cls   = ((hc_q + 3'd1) == xed_pkg::NAME_LEN[i]) ? xed_pkg::CLS_FULL
                                                         : xed_pkg::CLS_PREFIX;
      end
    end
  end

  // Decide what happens to the byte
  assign is_amp    = (in_byte_i == xed_pkg::AMP_CHAR);
  assign match     = in_ref_q && (cls == xed_pkg::CLS_FULL);
  assign hold_ok   = in_ref_q && (cls == xed_pkg::CLS_PREFIX) && (hc_q < 3'(xed_pkg::HELD_MAX));
  assign flush1    = in_ref_q && !match && !hold_ok;
  assign plain     = !in_ref_q || flush1;
  assign emit_en   = match || (plain && !is_amp);
  assign emit_byte = match ? xed_pkg::NAME_CHAR[which] : in_byte_i;
  assign flush2    = end_of_text_i && (hold_ok || (plain && is_amp));

  // Next reference state; end of text always leaves it idle
  always_comb begin
    in_ref_d = (hold_ok || (plain && is_amp)) && !end_of_text_i;
    hc_d     = (hold_ok && !end_of_text_i) ? hc_q + 3'd1 : 3'd0;
  end

  // Assemble the output words in order
  always_comb begin
    ob = '0;
    n  = 3'd0;
    if (flush1) begin
      ob[0] = xed_pkg::AMP_CHAR;
      for (int k = 0; k < xed_pkg::HELD_MAX; k++) begin
        ob[k+1] = held_q[k];
      end
      n = hc_q + 3'd1;
    end
    if (emit_en) begin
      ob[n] = emit_byte;
      n     = n + 3'd1;
    end
    if (flush2) begin
      if (hold_ok) begin
        // nothing emitted yet: ampersand, held letters, then this byte
        ob[0] = xed_pkg::AMP_CHAR;
        for (int k = 0; k < xed_pkg::HELD_MAX; k++) begin
          ob[k+1] = held_q[k];
        end
        ob[hc_q+3'd1] = in_byte_i;
        n = hc_q + 3'd2;
      end else begin
        ob[n] = xed_pkg::AMP_CHAR;
        n     = n + 3'd1;
      end
    end
  end

  assign job_valid_o    = (n != 3'd0);
  assign job_o.bytes    = ob;
  assign job_o.count    = n;
  assign job_o.text_end = end_of_text_i;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ref_q <= 1'b0;
      hc_q     <= 3'd0;
    end else if (accept_i) begin
      in_ref_q <= in_ref_d;
      hc_q     <= hc_d;
    end
  end

  // Held letters, meaningful only below the held count
  always_ff @(posedge clk_i) begin
    if (accept_i && hold_ok) begin
      held_q[hc_q[1:0]] <= in_byte_i;
    end
  end

`ifndef ASSERT_OFF
  a_held_needs_ref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hc_q != 3'd0) |-> in_ref_q)
    else $error("held letters without a pending ampersand");

  a_end_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && end_of_text_i) |=> (!in_ref_q && hc_q == 3'd0))
    else $error("reference still pending after end of text");

  a_end_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && end_of_text_i) |-> job_valid_o)
    else $error("final byte produced no word");
`endif

endmodule
`default_nettype wire

FILE: src/xed_job_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xed_job_fifo: job queue between front and back end
// Small register queue of jobs; the head entry is visible while not empty.
// ----------------------------------------------------------------------------
module xed_job_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire xed_pkg::job_t job_i,
  input  wire logic          pop_i,
  output xed_pkg::job_t      head_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  xed_pkg::job_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !pop_i) |-> !push_i)
    else $error("job queue overflow");
`endif

endmodule
`default_nettype wire

FILE: src/xed_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xed_back: word sequencer
// Steps through the words of the head job, one word per pop, and retires the
// job after its last word.
// ----------------------------------------------------------------------------
module xed_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire xed_pkg::job_t head_i,
  input  wire logic          empty_i,
  input  wire logic          pop_i,
  output logic               job_pop_o,
  output logic [7:0]         out_byte_o,
  output logic               run_last_o,
  output logic               text_done_o
);

  logic [2:0] idx_q;
  logic       last_word;
  logic       take;

  assign take        = pop_i && !empty_i;
  assign last_word   = (idx_q == head_i.count - 3'd1);
  assign job_pop_o   = take && last_word;
  assign out_byte_o  = head_i.bytes[idx_q];
  assign run_last_o  = last_word;
  assign text_done_o = last_word && head_i.text_end;

  // Word index within the head job
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
    end else if (take) begin
      idx_q <= last_word ? 3'd0 : idx_q + 3'd1;
    end
  end

`ifndef ASSERT_OFF
  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (idx_q < head_i.count))
    else $error("word index beyond head job");
`endif

endmodule
`default_nettype wire

FILE: src/xml_entity_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xml_entity_decoder: predefined entity decoder
// Replaces &quot; &amp; &lt; &gt; in a byte stream, passes other bytes on.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle while full is low; full rises only when
// JobDepth jobs are queued. Each byte causes 0 to 6 result words (broken or
// unfinished references come out as plain text), which leave one word per
// cycle while pop is high. The first word of a byte is visible once its job,
// registered in the job queue, reaches the queue head. Sustained input
// rate is one byte per cycle as long as results are popped every cycle and
// bursts are short; the output sequencer, at one word per cycle, sets the
// limit otherwise.
// ----------------------------------------------------------------------------
module xml_entity_decoder #(
  parameter int unsigned JobDepth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_of_text_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            text_done_o
);

  logic          accept;
  logic          job_valid;
  xed_pkg::job_t job, head;
  logic          job_pop;
  logic          q_full;

  assign full   = q_full;
  assign accept = push && !q_full;

  xed_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .job_valid_o   (job_valid),
    .job_o         (job)
  );

  xed_job_fifo #(
    .Depth (JobDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && job_valid),
    .job_i   (job),
    .pop_i   (job_pop),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (empty)
  );

  xed_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_i       (pop),
    .job_pop_o   (job_pop),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .text_done_o (text_done_o)
  );

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: entity decoder check
// Streams text bytes into the decoder and checks every output word against
// a local decoder of the four predefined references. A short directed text
// comes first, then random reference fragments and noise, with random gaps
// on both sides, a long output hold-off and a full drain in between.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned WatchLimit = 3000;  // cycles with no word moving
  localparam int unsigned TailCycles = 40;
  localparam int unsigned HoldCycles = 400;

  typedef struct {
    logic [7:0]  data;
    logic        eot;
    int unsigned gap;
    bit          drain;  // wait until every expected word has come out
  } text_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_done;
  } word_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       push        = 1'b0;
  logic       full;
  logic [7:0] in_byte     = 8'h00;
  logic       end_of_text = 1'b0;
  logic       empty;
  logic       pop         = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_done;

  xml_entity_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .in_byte_i     (in_byte),
    .end_of_text_i (end_of_text),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte),
    .run_last_o    (run_last),
    .text_done_o   (text_done)
  );

  always #5 clk_i = ~clk_i;

  // Pending text and decoded words still to come out
  text_item_t  text_q [$];
  word_t       decoded_q [$];
  int unsigned exp_cnt = 0;  // size of decoded_q as of the last edge
  int unsigned n_fail  = 0;

  // Local decoder state
  bit          ref_open = 1'b0;
  logic [7:0]  held [xed_pkg::HELD_MAX];
  int unsigned held_n = 0;
  logic [7:0]  burst [$];

  function void put_word(input logic [7:0] b);
    if (burst.size() < xed_pkg::MAX_OUT) burst.push_back(b);
  endfunction

  function void take_plain(input logic [7:0] b);
    if (b == xed_pkg::AMP_CHAR) begin
      ref_open = 1'b1;
      held_n   = 0;
    end else begin
      put_word(b);
    end
  endfunction

  // Pending reference comes out as plain text
  function void flush_held();
    put_word(xed_pkg::AMP_CHAR);
    for (int k = 0; k < held_n; k++) put_word(held[k]);
    ref_open = 1'b0;
    held_n   = 0;
  endfunction

  function xed_pkg::cls_e match_name(input logic [7:0] b, output int unsigned which);
    int unsigned len;
    bit          ok;
    len   = held_n + 1;
    which = 0;
    for (int i = 0; i < xed_pkg::NUM_NAMES; i++) begin
      if (len <= xed_pkg::NAME_LEN[i]) begin
        ok = 1'b1;
        for (int k = 0; k < held_n; k++) begin
          if (held[k] != xed_pkg::NAME_TEXT[i][k]) ok = 1'b0;
        end
        if (ok && xed_pkg::NAME_TEXT[i][len-1] == b) begin
          which = i;
          if (len == xed_pkg::NAME_LEN[i]) return xed_pkg::CLS_FULL;
          return xed_pkg::CLS_PREFIX;
        end
      end
    end
    return xed_pkg::CLS_BREAK;
  endfunction

  // Words caused by one accepted byte
  function void decode_byte(input logic [7:0] b, input logic last);
    int unsigned   which;
    xed_pkg::cls_e verdict;
    word_t         w;
    burst.delete();
    if (!ref_open) begin
      take_plain(b);
    end else begin
      verdict = match_name(b, which);
      if (verdict == xed_pkg::CLS_FULL) begin
        put_word(xed_pkg::NAME_CHAR[which]);
        ref_open = 1'b0;
        held_n   = 0;
      end else if (verdict == xed_pkg::CLS_PREFIX && held_n < xed_pkg::HELD_MAX) begin
        held[held_n] = b;
        held_n++;
      end else begin
        flush_held();
        take_plain(b);
      end
    end
    if (last && ref_open) flush_held();
    for (int k = 0; k < burst.size(); k++) begin
      w.out_byte  = burst[k];
      w.run_last  = (k == burst.size() - 1);
      w.text_done = w.run_last && last;
      decoded_q.push_back(w);
    end
  endfunction

  // Stimulus building
  bit tx_quick      = 1'b0;
  bit tx_drain_next = 1'b0;

  function void add_byte(input logic [7:0] b, input logic last);
    text_item_t it;
    it.data       = b;
    it.eot        = last;
    it.gap        = tx_quick ? 0 : $urandom_range(0, 13);
    it.drain      = tx_drain_next;
    tx_drain_next = 1'b0;
    text_q.push_back(it);
  endfunction

  function void add_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], last && (i == s.len() - 1));
  endfunction

  // Driver: one byte at a time from text_q
  bit          tx_took;
  bit          tx_go;
  bit          tx_loaded = 1'b0;
  int unsigned tx_wait   = 0;
  text_item_t  tx_cur;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push        <= 1'b0;
      in_byte     <= 8'h00;
      end_of_text <= 1'b0;
      tx_loaded   = 1'b0;
      tx_wait     = 0;
    end else begin
      tx_took = push && !full;
      tx_go   = push && !tx_took;
      if (!tx_go) begin
        if (!tx_loaded && text_q.size() != 0) begin
          tx_cur    = text_q.pop_front();
          tx_loaded = 1'b1;
          tx_wait   = tx_cur.gap;
        end
        // a drain item waits for the decoded words of everything before it
        if (tx_loaded && !(tx_cur.drain && (tx_took || exp_cnt != 0))) begin
          if (tx_wait != 0) begin
            tx_wait--;
          end else begin
            tx_go       = 1'b1;
            in_byte     <= tx_cur.data;
            end_of_text <= tx_cur.eot;
            tx_loaded   = 1'b0;
          end
        end
      end
      push <= tx_go;
    end
  end

  // Monitor: predicts on each taken byte, checks each popped word
  bit          rx_took;
  bit          rx_quick  = 1'b0;
  bit          rx_held   = 1'b0;
  int unsigned rx_wait   = 0;
  int unsigned rx_hold   = 0;
  int unsigned words_out = 0;
  word_t       rx_want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop     <= 1'b0;
      exp_cnt <= 0;
      rx_wait = 0;
      rx_hold = 0;
    end else begin
      if (push && !full) decode_byte(in_byte, end_of_text);
      rx_took = pop && !empty;
      if (rx_took) begin
        if (decoded_q.size() == 0) begin
          $error("out_byte: nothing expected, got 0x%02h", out_byte);
          n_fail++;
        end else begin
          rx_want = decoded_q.pop_front();
          if (out_byte !== rx_want.out_byte) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", rx_want.out_byte, out_byte);
            n_fail++;
          end
          if (run_last !== rx_want.run_last) begin
            $error("run_last: expected %0b, got %0b", rx_want.run_last, run_last);
            n_fail++;
          end
          if (text_done !== rx_want.text_done) begin
            $error("text_done: expected %0b, got %0b", rx_want.text_done, text_done);
            n_fail++;
          end
        end
        words_out++;
        // one long hold-off so the decoder fills up and raises full
        if (words_out == 40 && !rx_held) begin
          rx_hold = HoldCycles;
          rx_held = 1'b1;
        end
        if (words_out % 32 == 0) rx_quick = ($urandom_range(0, 2) == 0);
        rx_wait = rx_quick ? 0 : $urandom_range(0, 13);
      end
      if (rx_hold != 0) begin
        rx_hold--;
        pop <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
      exp_cnt <= decoded_q.size();
    end
  end

  // Watchdog on cycles where no word moves
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Text generation, reset and end of run
  int unsigned kind;
  int unsigned nm;
  int unsigned plen;
  bit          end_here;
  bit          mid_drain = 1'b0;
  logic [7:0]  seg [$];

  initial begin
    // Directed: each reference, lone ampersand, ampersand inside a
    // reference, broken reference, byte extremes, pending reference at end
    add_text("&lt;", 1'b0);
    add_text("&gt;", 1'b0);
    add_text("&amp;", 1'b0);
    add_text("&quot;", 1'b0);
    add_text("&&", 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_text("&g", 1'b1);

    // Random: mostly reference fragments, some plain noise
    tx_drain_next = 1'b1;
    while (text_q.size() < 225) begin
      tx_quick = ($urandom_range(0, 3) == 0);
      kind     = $urandom_range(0, 9);
      nm       = $urandom_range(0, xed_pkg::NUM_NAMES - 1);
      end_here = ($urandom_range(0, 7) == 0);
      seg.delete();
      if (kind <= 6) begin
        seg.push_back(xed_pkg::AMP_CHAR);
        if (kind <= 3) plen = xed_pkg::NAME_LEN[nm];
        else plen = $urandom_range(0, int'(xed_pkg::NAME_LEN[nm]) - 1);
        for (int k = 0; k < plen; k++) seg.push_back(xed_pkg::NAME_TEXT[nm][k]);
        if (kind == 4 || kind == 5) seg.push_back(8'($urandom_range(0, 255)));
        if (kind == 6) end_here = 1'b1;
      end else if (kind <= 8) begin
        repeat ($urandom_range(1, 4)) seg.push_back(8'($urandom_range(0, 255)));
      end else begin
        seg.push_back(xed_pkg::AMP_CHAR);
        seg.push_back(xed_pkg::AMP_CHAR);
        seg.push_back(xed_pkg::NAME_TEXT[nm][0]);
      end
      if (!mid_drain && text_q.size() >= 130) begin
        tx_drain_next = 1'b1;
        mid_drain     = 1'b1;
      end
      for (int k = 0; k < seg.size(); k++) add_byte(seg[k], end_here && (k == seg.size() - 1));
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (text_q.size() != 0 || tx_loaded || push || exp_cnt != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    if (decoded_q.size() != 0) begin
      $error("out_byte: %0d expected words never came out", decoded_q.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/xed_pkg.sv
src/xed_front.sv
src/xed_job_fifo.sv
src/xed_back.sv
src/xml_entity_decoder.sv
tb/testbench.sv
